FILE: sv/gtb_pkg.sv
// Shared types, constants and register indexes for the glyph text blitter.
package gtb_pkg;

   localparam int SCREEN_WIDTH_DEF = 800;
   localparam int FONT_ENTRIES_DEF = 4096;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);
   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 16;

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_DRAW = 2'd1;
   localparam logic [1:0] CMD_HOME = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_CHAR_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CHAR_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LINE_LENGTH = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_X    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_Y    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_FG_COLOR    = 3'd5;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  char_code;
      logic [11:0] font_index;
      logic [7:0]  font_byte;
   } req_type;

   typedef struct packed {
      logic [19:0] pixel_address;
      logic [7:0]  pixel_mask;
      logic [15:0] color;
      logic        last_row;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  char_width;
      logic [4:0]  char_height;
      logic [9:0]  line_length;
      logic [9:0]  origin_x;
      logic [8:0]  origin_y;
      logic [15:0] fg_color;
   } gtb_cfg_type;

   typedef struct packed {
      logic        is_load;
      logic [15:0] row;
      logic [9:0]  col;
      logic [11:0] font_addr;
      logic [4:0]  height;
      logic [7:0]  wmask;
      logic [7:0]  font_byte;
   } gtb_job_type;

endpackage

FILE: sv/gtb_front.sv
// Front end: accepts words, tracks the text cursor and queues load and draw jobs.
module gtb_front
   import gtb_pkg::*;
#(
   parameter int FONT_ENTRIES = FONT_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  gtb_cfg_type cfg,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        q_push,
   output gtb_job_type q_data,
   input  logic        q_full
);

   logic [9:0]  col_ff;
   logic [15:0] row_ff;
   logic [9:0]  line_pos_ff;
   logic [3:0]  gw_eff;
   logic [4:0]  gh_eff;
   logic        wrap;
   logic [9:0]  col_start;
   logic [15:0] row_start;
   logic [9:0]  lp_start;
   logic        accept;
   logic        is_load;
   logic        is_draw;

   always_comb begin
      if (cfg.char_width == 4'd0) begin
         gw_eff = 4'd1;
      end else if (cfg.char_width > 4'd8) begin
         gw_eff = 4'd8;
      end else begin
         gw_eff = cfg.char_width;
      end
      if (cfg.char_height == 5'd0) begin
         gh_eff = 5'd1;
      end else if (cfg.char_height > 5'd16) begin
         gh_eff = 5'd16;
      end else begin
         gh_eff = cfg.char_height;
      end
   end

   assign wrap      = ({1'b0, line_pos_ff} + 11'(gw_eff)) > {1'b0, cfg.line_length};
   assign col_start = wrap ? cfg.origin_x : col_ff;
   assign row_start = wrap ? row_ff + 16'(gh_eff) : row_ff;
   assign lp_start  = wrap ? 10'd0 : line_pos_ff;

   assign accept    = req_valid && !q_full;
   assign req_stall = q_full;
   assign is_load   = (req_data.cmd == CMD_LOAD) &&
                      ({1'b0, req_data.font_index} < 13'(FONT_ENTRIES));
   assign is_draw   = (req_data.cmd == CMD_DRAW) && (req_data.char_code != 8'd0);
   assign q_push    = accept && (is_load || is_draw);

   always_comb begin
      q_data.is_load   = is_load;
      q_data.row       = row_start;
      q_data.col       = col_start;
      q_data.font_addr = is_load ? req_data.font_index :
                         12'(13'(req_data.char_code) * 13'(gh_eff));
      q_data.height    = gh_eff;
      q_data.wmask     = 8'((16'd1 << gw_eff) - 16'd1);
      q_data.font_byte = req_data.font_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         line_pos_ff <= '0;
      end else if (accept) begin
         if (req_data.cmd == CMD_HOME) begin
            col_ff      <= cfg.origin_x;
            row_ff      <= {7'd0, cfg.origin_y};
            line_pos_ff <= '0;
         end else if (is_draw) begin
            col_ff      <= col_start + 10'(gw_eff);
            row_ff      <= row_start;
            line_pos_ff <= lp_start + 10'(gw_eff);
         end
      end
   end

endmodule

FILE: sv/gtb_queue.sv
// Short job queue between the front end and the row engine.
module gtb_queue
   import gtb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  gtb_job_type push_data,
   output logic        full,
   output logic        valid,
   input  logic        pop,
   output gtb_job_type head
);

   gtb_job_type            entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff;
   logic                   do_push;
   logic                   do_pop;

   assign full    = count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
   assign valid   = count_ff != '0;
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: sv/gtb_back.sv
// Row engine: owns the font store, runs load jobs and emits one word per glyph row.
module gtb_back
   import gtb_pkg::*;
#(
   parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
   parameter int FONT_ENTRIES = FONT_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  gtb_cfg_type cfg,
   input  logic        q_valid,
   input  gtb_job_type q_head,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   localparam int AW = $clog2(FONT_ENTRIES);

   typedef enum logic [1:0] {S_IDLE, S_BASE, S_ROWS} state_type;

   state_type   state_ff;
   gtb_job_type job_ff;
   logic [19:0] addr_ff;
   logic [11:0] font_addr_ff;
   logic [3:0]  row_idx_ff;
   logic        pend_valid_ff;
   logic [19:0] pend_addr_ff;
   logic        pend_last_ff;
   logic        pend_oor_ff;
   logic [7:0]  pend_mask_ff;
   logic [7:0]  rdata_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   logic [7:0]  font_mem [FONT_ENTRIES];

   logic        row_last;
   logic        font_in_range;
   logic [31:0] base_full;
   logic        mem_we;
   logic        move;
   logic        issue;

   assign row_last      = {1'b0, row_idx_ff} == (job_ff.height - 5'd1);
   assign font_in_range = {1'b0, font_addr_ff} < 13'(FONT_ENTRIES);
   assign base_full     = 32'(job_ff.row) * 32'(SCREEN_WIDTH) + 32'(job_ff.col);
   assign q_pop         = (state_ff == S_IDLE) && q_valid;
   assign mem_we        = q_pop && q_head.is_load;
   assign move          = pend_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign issue         = (state_ff == S_ROWS) && (!pend_valid_ff || move);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         font_mem[q_head.font_addr[AW-1:0]] <= q_head.font_byte;
      end
      if (issue && font_in_range) begin
         rdata_ff <= font_mem[font_addr_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (q_valid && !q_head.is_load) begin
                  job_ff   <= q_head;
                  state_ff <= S_BASE;
               end
            end
            S_BASE: begin
               addr_ff      <= base_full[19:0];
               font_addr_ff <= job_ff.font_addr;
               row_idx_ff   <= '0;
               state_ff     <= S_ROWS;
            end
            S_ROWS: begin
               if (issue) begin
                  addr_ff      <= addr_ff + 20'(SCREEN_WIDTH);
                  font_addr_ff <= font_addr_ff + 12'd1;
                  row_idx_ff   <= row_idx_ff + 4'd1;
                  pend_addr_ff <= addr_ff;
                  pend_last_ff <= row_last;
                  pend_oor_ff  <= !font_in_range;
                  pend_mask_ff <= job_ff.wmask;
                  if (row_last) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         if (issue) begin
            pend_valid_ff <= 1'b1;
         end else if (move) begin
            pend_valid_ff <= 1'b0;
         end

         if (move) begin
            rsp_valid_ff              <= 1'b1;
            rsp_data_ff.pixel_address <= pend_addr_ff;
            rsp_data_ff.pixel_mask    <= pend_oor_ff ? 8'd0 : (rdata_ff & pend_mask_ff);
            rsp_data_ff.color         <= cfg.fg_color;
            rsp_data_ff.last_row      <= pend_last_ff;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_last_row_ends_job: assert property (@(posedge clock) disable iff (reset)
      issue && row_last |=> state_ff == S_IDLE)
      else $error("row engine did not return to idle after the last row");

   a_pending_row_held: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff && !move |=> pend_valid_ff && $stable(pend_addr_ff) && $stable(rdata_ff))
      else $error("pending row was lost or changed while the output was full");

   a_row_index_in_glyph: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROWS |-> {1'b0, row_idx_ff} < job_ff.height)
      else $error("row index ran past the glyph height");

   a_no_load_during_rows: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !issue)
      else $error("font load overlapped a row read");

endmodule

FILE: sv/glyph_text_blitter.sv
// A draw word passes the job queue, the idle, base and row states, the pending-row register and
// the output register, then gives one row word per cycle while rsp_stall is low.
// Cursor and ignored words never reach the row engine; the front takes one word per cycle
// while its four-entry job queue has room.
// Synchronous reset restores register defaults, homes the cursor and empties the queue;
// the font store is not cleared and holds undefined data until loaded.
module glyph_text_blitter
   import gtb_pkg::*;
#(
   parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
   parameter int FONT_ENTRIES = FONT_ENTRIES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   gtb_cfg_type cfg_ff;
   logic        q_push;
   gtb_job_type q_data;
   logic        q_full;
   logic        q_valid;
   logic        q_pop;
   gtb_job_type q_head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.char_width  <= 4'd8;
         cfg_ff.char_height <= 5'd8;
         cfg_ff.line_length <= 10'd800;
         cfg_ff.origin_x    <= '0;
         cfg_ff.origin_y    <= '0;
         cfg_ff.fg_color    <= 16'hFFFF;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_CHAR_WIDTH:  cfg_ff.char_width  <= csr_data[3:0];
            REG_CHAR_HEIGHT: cfg_ff.char_height <= csr_data[4:0];
            REG_LINE_LENGTH: cfg_ff.line_length <= csr_data[9:0];
            REG_ORIGIN_X:    cfg_ff.origin_x    <= csr_data[9:0];
            REG_ORIGIN_Y:    cfg_ff.origin_y    <= csr_data[8:0];
            REG_FG_COLOR:    cfg_ff.fg_color    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   gtb_front #(
      .FONT_ENTRIES(FONT_ENTRIES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .q_push   (q_push),
      .q_data   (q_data),
      .q_full   (q_full)
   );

   gtb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_data),
      .full     (q_full),
      .valid    (q_valid),
      .pop      (q_pop),
      .head     (q_head)
   );

   gtb_back #(
      .SCREEN_WIDTH(SCREEN_WIDTH),
      .FONT_ENTRIES(FONT_ENTRIES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (q_valid),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

FILE: tb/tb_glyph_text_blitter.sv
`timescale 1ns / 1ps
// Self-checking testbench for the glyph text blitter: random draw, font load and cursor words.
module tb_glyph_text_blitter;
   import gtb_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 40;
   localparam int SQUEEZE_HOLD  = 300;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [63:0] ROW_PATTERNS = 64'hF00F_55AA_8001_00FF;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   logic [3:0]  cfg_width = 4'd8;
   logic [4:0]  cfg_height = 5'd8;
   logic [9:0]  cfg_line = 10'd800;
   logic [9:0]  cfg_org_x = '0;
   logic [8:0]  cfg_org_y = '0;
   logic [15:0] cfg_fg = 16'hFFFF;
   logic [9:0]  cur_col = '0;
   logic [15:0] cur_row = '0;
   logic [9:0]  line_used = '0;
   logic [7:0]  font_img [FONT_ENTRIES_DEF];
   bit          font_planned [FONT_ENTRIES_DEF];

   req_type     words_to_send [$];
   rsp_type     rows_due [$];
   int          mismatches = 0;
   int          sender_gap = 0;
   int          stall_left = 0;
   int          hold_left = 0;
   bit          calm = 1'b0;
   bit          squeeze_req = 1'b0;
   int unsigned cycle_count = 0;

   glyph_text_blitter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int glyph_cols();
      if (cfg_width == 4'd0) return 1;
      if (cfg_width > 4'd8) return 8;
      return int'(cfg_width);
   endfunction

   function automatic int glyph_rows();
      if (cfg_height == 5'd0) return 1;
      if (cfg_height > 5'd16) return 16;
      return int'(cfg_height);
   endfunction

   // A small set of codes keeps the number of font loads low; code 255 reaches the top
   // of the font store.
   function automatic logic [7:0] pick_code();
      int k;
      k = $urandom_range(0, 2);
      if (k == 0) return 8'd1;
      if (k == 1) return 8'd2;
      return 8'd255;
   endfunction

   task automatic render_glyph(input logic [7:0] code);
      int         gw;
      int         gh;
      int         idx;
      int         i;
      logic [7:0] wmask;
      longint     addr;
      rsp_type    row_word;
      gw = glyph_cols();
      gh = glyph_rows();
      wmask = 8'((1 << gw) - 1);
      if (int'(line_used) + gw > int'(cfg_line)) begin
         cur_col = cfg_org_x;
         cur_row = cur_row + 16'(gh);
         line_used = '0;
      end
      for (i = 0; i < gh; i++) begin
         idx = int'(code) * gh + i;
         addr = (longint'(cur_row) + i) * SCREEN_WIDTH_DEF + longint'(cur_col);
         row_word.pixel_address = 20'(addr);
         row_word.pixel_mask = (idx < FONT_ENTRIES_DEF) ? (font_img[idx] & wmask) : 8'd0;
         row_word.color = cfg_fg;
         row_word.last_row = (i == gh - 1);
         rows_due.push_back(row_word);
      end
      cur_col = cur_col + 10'(gw);
      line_used = line_used + 10'(gw);
   endtask

   task automatic take_word(input req_type w);
      case (w.cmd)
         CMD_LOAD: font_img[w.font_index] = w.font_byte;
         CMD_DRAW: if (w.char_code != 8'd0) render_glyph(w.char_code);
         CMD_HOME: begin
            cur_col = cfg_org_x;
            cur_row = 16'(cfg_org_y);
            line_used = '0;
         end
         default: ;
      endcase
   endtask

   function automatic req_type noise_word(input logic [1:0] cmd);
      logic [31:0] noise;
      req_type     w;
      noise = $urandom;
      w = noise[$bits(req_type)-1:0];
      w.cmd = cmd;
      return w;
   endfunction

   task automatic queue_load(input int idx, input logic [7:0] pattern);
      req_type w;
      w = noise_word(CMD_LOAD);
      w.font_index = 12'(idx);
      w.font_byte = pattern;
      font_planned[idx] = 1'b1;
      words_to_send.push_back(w);
   endtask

   // Rows of the glyph that were never loaded get a load word first.
   task automatic queue_draw(input logic [7:0] code);
      req_type w;
      int      gh;
      int      i;
      int      idx;
      gh = glyph_rows();
      if (code != 8'd0) begin
         for (i = 0; i < gh; i++) begin
            idx = int'(code) * gh + i;
            if (!font_planned[idx]) queue_load(idx, 8'($urandom));
         end
      end
      w = noise_word(CMD_DRAW);
      w.char_code = code;
      words_to_send.push_back(w);
   endtask

   task automatic queue_random(input int n, input int draw_pct, input bit homing);
      int counted;
      int r;
      counted = 0;
      while (counted < n) begin
         r = $urandom_range(0, 99);
         if (r < draw_pct) begin
            queue_draw(pick_code());
            counted++;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 45 || (r < 65 && !homing)) begin
               queue_load($urandom_range(0, FONT_ENTRIES_DEF - 1), 8'($urandom));
               counted++;
            end else if (r < 65) begin
               words_to_send.push_back(noise_word(CMD_HOME));
               counted++;
            end else if (r < 85) begin
               queue_draw(8'd0);
            end else begin
               words_to_send.push_back(noise_word(CMD_UNUSED));
            end
         end
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int value);
      logic [CSR_DATA_W-1:0] v;
      v = CSR_DATA_W'(value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_CHAR_WIDTH:  cfg_width = v[3:0];
         REG_CHAR_HEIGHT: cfg_height = v[4:0];
         REG_LINE_LENGTH: cfg_line = v[9:0];
         REG_ORIGIN_X:    cfg_org_x = v[9:0];
         REG_ORIGIN_Y:    cfg_org_y = v[8:0];
         REG_FG_COLOR:    cfg_fg = v[15:0];
         default: ;
      endcase
   endtask

   task automatic set_regs(input int gw, input int gh, input int len, input int ox,
                           input int oy, input int fg);
      write_reg(REG_CHAR_WIDTH, gw);
      write_reg(REG_CHAR_HEIGHT, gh);
      write_reg(REG_LINE_LENGTH, len);
      write_reg(REG_ORIGIN_X, ox);
      write_reg(REG_ORIGIN_Y, oy);
      write_reg(REG_FG_COLOR, fg);
   endtask

   task automatic set_random_regs();
      set_regs($urandom_range(1, 8), $urandom_range(1, 16), $urandom_range(1, 800),
               $urandom_range(0, 799), $urandom_range(0, 479), $urandom_range(0, 65535));
   endtask

   task automatic drain();
      do @(negedge clock);
      while (words_to_send.size() != 0 || req_valid || rows_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic int sender_pause();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         sender_gap <= 0;
      end else begin
         if (req_valid && !req_stall) take_word(req_data);
         if (!req_valid || !req_stall) begin
            if (sender_gap > 0) begin
               req_valid <= 1'b0;
               sender_gap <= sender_gap - 1;
            end else if (words_to_send.size() != 0) begin
               req_data <= words_to_send.pop_front();
               req_valid <= 1'b1;
               sender_gap <= sender_pause();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // The one long hold-off lets the job queue fill while words keep coming.
   always @(posedge clock) begin
      int r;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (squeeze_req && rsp_valid) begin
         rsp_stall <= 1'b1;
         hold_left <= SQUEEZE_HOLD;
         squeeze_req <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         r = $urandom_range(0, 99);
         if (calm || r < 70) begin
            rsp_stall <= 1'b0;
         end else if (r < 94) begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(8, 30);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rows_due.size() == 0) begin
            $error("unexpected row word: pixel_address %0h pixel_mask %0h",
                   rsp_data.pixel_address, rsp_data.pixel_mask);
            mismatches++;
         end else begin
            want = rows_due.pop_front();
            if (rsp_data.pixel_address !== want.pixel_address) begin
               $error("pixel_address: expected %0h, actual %0h",
                      want.pixel_address, rsp_data.pixel_address);
               mismatches++;
            end
            if (rsp_data.pixel_mask !== want.pixel_mask) begin
               $error("pixel_mask: expected %0h, actual %0h",
                      want.pixel_mask, rsp_data.pixel_mask);
               mismatches++;
            end
            if (rsp_data.color !== want.color) begin
               $error("color: expected %0h, actual %0h", want.color, rsp_data.color);
               mismatches++;
            end
            if (rsp_data.last_row !== want.last_row) begin
               $error("last_row: expected %0b, actual %0b", want.last_row, rsp_data.last_row);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int i;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      set_regs(8, 8, 800, 0, 0, 16'hFFFF);
      words_to_send.push_back('1);
      queue_draw(8'd0);
      for (i = 0; i < 8; i++) queue_load(255 * 8 + i, ROW_PATTERNS[8*i +: 8]);
      queue_draw(8'd255);
      queue_load(FONT_ENTRIES_DEF - 1, 8'hFF);
      queue_load(0, 8'h00);
      queue_draw(8'd1);
      words_to_send.push_back(noise_word(CMD_HOME));
      queue_draw(8'd255);
      drain();

      // Tall glyphs with a line length of one wrap on every character, so each starts a glyph height lower.
      set_regs(1, 16, 1, 799, 479, 0);
      queue_random(10, 85, 1'b0);
      drain();

      set_regs(8, 16, 8, 795, 479, $urandom_range(0, 65535));
      squeeze_req = 1'b1;
      queue_random(30, 85, 1'b0);
      drain();

      set_regs(0, 0, $urandom_range(1, 800), $urandom_range(0, 799), $urandom_range(0, 479),
               $urandom_range(0, 65535));
      queue_random(10, 60, 1'b1);
      drain();

      set_regs(15, 31, 800, 799, $urandom_range(0, 479), $urandom_range(0, 65535));
      words_to_send.push_back(noise_word(CMD_HOME));
      queue_random(15, 85, 1'b0);
      drain();

      calm = 1'b1;
      set_random_regs();
      queue_random(10, 60, 1'b1);
      drain();
      calm = 1'b0;

      set_random_regs();
      queue_random(10, 60, 1'b1);
      drain();

      if (mismatches == 0 && rows_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
